FILE: hdl/lpr_pkg.sv
// Shared types and constants for the length-prefixed request parser.
`default_nettype none

package lpr_pkg;

    localparam int unsigned SIZE_BITS_DEF  = 32;
    localparam logic [15:0] MAX_ARGS_RESET = 16'd1024;
    localparam int unsigned FIELD_BYTES    = 4;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 4;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_TOOMANY,
        ST_TRUNC,
        ST_TRAIL
    } t_status;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_LENGTH,
        KIND_DATA,
        KIND_IGNORED
    } t_kind;

    typedef struct packed {
        t_kind       byte_kind;
        logic [7:0]  data_byte;
        logic [15:0] arg_index;
        logic        arg_start;
        logic        arg_end;
        logic        msg_done;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/length_prefixed_request_parser_top.sv
// Top level of the length-prefixed request parser: byte classifier and output skid buffer.
//
// Usage: a request message enters one byte per item on the s_axis channel, with
// s_axis_tlast high on its final byte. The message is a 4-byte little-endian
// argument count, then for each argument a 4-byte little-endian length and that
// many data bytes. Every input item yields exactly one result item on m_axis:
// the byte passed through, its role (header, length, data, ignored), its
// argument index, start and end marks, and a status. On the final byte
// (m_axis_tlast) the status is the verdict for the whole message.
// The configuration channel writes max_args, the largest accepted argument
// count; write it only while no message bytes are in flight.
// Each accepted byte's result is registered in the output or skid register. The block
// sustains one byte per cycle while m_axis_tready is high; the per-byte state update is
// a single combinational pass between the parser state registers and the output register.
// When the receiver stalls, one further result is caught in a skid register,
// after which s_axis_tready drops until the output drains; nothing is lost.
// Reset returns the parser to the start of a message, sets max_args to 1024
// and empties both output registers. The parser also returns to the start of
// a message after every final byte; max_args is kept.
`default_nettype none

module length_prefixed_request_parser_top #(
    parameter int unsigned SIZE_BITS = lpr_pkg::SIZE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration: max_args write.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [15:0]                    i_cfg_data,
    // Input bytes.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [lpr_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] msg_byte
    input  wire logic                           s_axis_tlast,   // last
    // Classified bytes.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] data_byte, [23:8] arg_index, [26:24] status, [31:27] zero
    output logic [lpr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [1:0] byte_kind, [2] arg_start, [3] arg_end
    output logic [lpr_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    output logic                                m_axis_tlast    // msg_done
);

    import lpr_pkg::*;

    // All ones in SIZE_BITS bits, seen as a 32-bit length.
    localparam logic [31:0] SizeMask = 32'((64'd1 << SIZE_BITS) - 64'd1);

    // Parser state.
    t_phase                r_phase,       n_phase;
    logic [1:0]            r_cnt,         n_cnt;
    logic [31:0]           r_field,       n_field;
    logic [15:0]           r_args_left,   n_args_left;
    logic [SIZE_BITS-1:0]  r_bytes_left,  n_bytes_left;
    logic [SIZE_BITS-1:0]  r_len,         n_len;
    logic [15:0]           r_cur_arg,     n_cur_arg;
    t_status               r_err,         n_err;
    logic [15:0]           r_max_args;

    // Output register and skid register.
    t_result               r_m_data;
    logic                  r_m_valid;
    t_result               r_s_data;
    logic                  r_s_valid;

    t_result               res;
    logic                  in_acc;
    logic                  load_m;
    logic [31:0]           word;
    logic [7:0]            b;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_s_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_m        = !r_m_valid || m_axis_tready;
    assign b             = s_axis_tdata[7:0];

    // One byte of parsing: next state and the result item.
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_field      = r_field;
        n_args_left  = r_args_left;
        n_bytes_left = r_bytes_left;
        n_len        = r_len;
        n_cur_arg    = r_cur_arg;
        n_err        = r_err;
        word         = r_field | (32'(b) << {r_cnt, 3'b000});

        res.byte_kind = KIND_IGNORED;
        res.data_byte = b;
        res.arg_index = r_cur_arg;
        res.arg_start = 1'b0;
        res.arg_end   = 1'b0;
        res.msg_done  = s_axis_tlast;

        if (r_err != ST_OK) begin
            res.byte_kind = KIND_IGNORED;
        end else begin
            case (r_phase)
                PH_HEADER, PH_LENGTH: begin
                    res.byte_kind = (r_phase == PH_HEADER) ? KIND_HEADER : KIND_LENGTH;
                    n_cnt   = r_cnt + 2'd1;
                    n_field = word;
                    if (r_cnt == 2'd3) begin
                        // Field complete: the assembled word is in word.
                        n_field = '0;
                        if (r_phase == PH_HEADER) begin
                            if (word > {16'd0, r_max_args}) begin
                                n_err = ST_TOOMANY;
                            end else begin
                                n_args_left = word[15:0];
                                n_phase = (word[15:0] != 16'd0) ? PH_LENGTH : PH_DONE;
                            end
                        end else if (word == 32'd0) begin
                            // Empty argument ends on its length field.
                            res.arg_end = 1'b1;
                            n_args_left = r_args_left - 16'd1;
                            n_cur_arg   = r_cur_arg + 16'd1;
                            n_phase = (r_args_left != 16'd1) ? PH_LENGTH : PH_DONE;
                        end else begin
                            // Lengths beyond SIZE_BITS are clamped to all ones.
                            n_len = (word > SizeMask) ? '1 : word[SIZE_BITS-1:0];
                            n_bytes_left = n_len;
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    res.byte_kind = KIND_DATA;
                    res.arg_start = (r_bytes_left == r_len);
                    n_bytes_left  = r_bytes_left - SIZE_BITS'(1);
                    if (r_bytes_left == SIZE_BITS'(1)) begin
                        res.arg_end = 1'b1;
                        n_args_left = r_args_left - 16'd1;
                        n_cur_arg   = r_cur_arg + 16'd1;
                        n_phase = (r_args_left != 16'd1) ? PH_LENGTH : PH_DONE;
                    end
                end
                default: begin
                    // All arguments done: any further byte is surplus.
                    res.byte_kind = KIND_IGNORED;
                    n_err = ST_TRAIL;
                end
            endcase
        end

        res.status = n_err;
        if (s_axis_tlast) begin
            if (n_err == ST_OK) begin
                if (n_phase == PH_HEADER) begin
                    res.status = ST_SHORT;
                end else if (n_phase != PH_DONE) begin
                    res.status = ST_TRUNC;
                end
            end
            // Back to the start of a message.
            n_phase      = PH_HEADER;
            n_cnt        = '0;
            n_field      = '0;
            n_args_left  = '0;
            n_bytes_left = '0;
            n_len        = '0;
            n_cur_arg    = '0;
            n_err        = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_cnt        <= '0;
            r_field      <= '0;
            r_args_left  <= '0;
            r_bytes_left <= '0;
            r_len        <= '0;
            r_cur_arg    <= '0;
            r_err        <= ST_OK;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_field      <= n_field;
            r_args_left  <= n_args_left;
            r_bytes_left <= n_bytes_left;
            r_len        <= n_len;
            r_cur_arg    <= n_cur_arg;
            r_err        <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args <= MAX_ARGS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_args <= i_cfg_data;
        end
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (load_m) begin
            if (r_s_valid) begin
                r_m_valid <= 1'b1;
                r_s_valid <= 1'b0;
            end else begin
                r_m_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_s_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_m) begin
            r_m_data <= r_s_valid ? r_s_data : res;
        end else if (in_acc) begin
            r_s_data <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_data.status, r_m_data.arg_index, r_m_data.data_byte};
    assign m_axis_tuser  = {r_m_data.arg_end, r_m_data.arg_start, r_m_data.byte_kind};
    assign m_axis_tlast  = r_m_data.msg_done;

endmodule

`default_nettype wire

FILE: hdl/lpr_checker.sv
// Port-level assertions for the length-prefixed request parser, bound to its top level.
`default_nettype none

module lpr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [lpr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [lpr_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input wire logic                          m_axis_tlast
);

    import lpr_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The start mark only appears on argument data.
    a_start_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == KIND_DATA)
        else $error("arg_start outside data");

    // An argument ends on a data byte or on the length field of an empty one.
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            (m_axis_tuser[1:0] == KIND_DATA || m_axis_tuser[1:0] == KIND_LENGTH))
        else $error("arg_end on wrong byte kind");

    // Length and data bytes are only parsed while no error is held.
    a_no_err_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast
            && (m_axis_tuser[1:0] == KIND_DATA || m_axis_tuser[1:0] == KIND_LENGTH)
            |-> m_axis_tdata[26:24] == ST_OK)
        else $error("parsed byte carries an error");

    // Header bytes belong to no argument yet.
    a_header_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == KIND_HEADER |-> m_axis_tdata[23:8] == 16'd0)
        else $error("header byte with nonzero argument index");

endmodule

bind length_prefixed_request_parser_top lpr_checker u_lpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/sv/lpr_result_checker.sv
// Checker that predicts the parser's classified bytes and compares them with the output.
`default_nettype none

module lpr_result_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [15:0]                    i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [lpr_pkg::S_TDATA_W-1:0]  i_in_data,   // [7:0] msg_byte
    input  wire logic                           i_in_last,   // last
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    // [7:0] data_byte, [23:8] arg_index, [26:24] status, [31:27] zero
    input  wire logic [lpr_pkg::M_TDATA_W-1:0]  i_out_data,
    // [1:0] byte_kind, [2] arg_start, [3] arg_end
    input  wire logic [lpr_pkg::M_TUSER_W-1:0]  i_out_user,
    input  wire logic                           i_out_last,  // msg_done
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpr_pkg::*;

    localparam int unsigned SIZE_BITS = SIZE_BITS_DEF;

    t_phase      parse_phase;
    logic [1:0]  field_count;
    logic [31:0] field_value;
    logic [15:0] args_left;
    logic [31:0] data_left;
    logic [15:0] arg_num;
    t_status     sticky;
    logic [15:0] max_args;

    t_result expected_labels[$];
    int      mismatches = 0;

    function automatic void clear_parse();
        parse_phase = PH_HEADER;
        field_count = '0;
        field_value = '0;
        args_left   = '0;
        data_left   = '0;
        arg_num     = '0;
        sticky      = ST_OK;
    endfunction

    function automatic void close_arg();
        args_left   = args_left - 16'd1;
        arg_num     = arg_num + 16'd1;
        parse_phase = (args_left != 16'd0) ? PH_LENGTH : PH_DONE;
    endfunction

    // Labels one message byte and advances the parse state.
    function automatic t_result classify_byte(input logic [7:0] b, input logic fin);
        t_result     r;
        logic [31:0] v;
        r.byte_kind = KIND_IGNORED;
        r.data_byte = b;
        r.arg_index = arg_num;
        r.arg_start = 1'b0;
        r.arg_end   = 1'b0;
        r.msg_done  = fin;
        if (sticky != ST_OK) begin
            r.byte_kind = KIND_IGNORED;
        end else if (parse_phase == PH_DONE) begin
            sticky = ST_TRAIL;
        end else if (parse_phase == PH_HEADER || parse_phase == PH_LENGTH) begin
            r.byte_kind = (parse_phase == PH_HEADER) ? KIND_HEADER : KIND_LENGTH;
            field_value = field_value | (32'(b) << {field_count, 3'b000});
            field_count = field_count + 2'd1;
            if (field_count == 2'd0) begin
                v = field_value;
                field_value = '0;
                if (parse_phase == PH_HEADER) begin
                    if (v > 32'(max_args)) begin
                        sticky = ST_TOOMANY;
                    end else begin
                        args_left   = v[15:0];
                        parse_phase = (args_left != 16'd0) ? PH_LENGTH : PH_DONE;
                    end
                end else if (v == 32'd0) begin
                    r.arg_end = 1'b1;
                    close_arg();
                end else begin
                    // Lengths wider than the size counter saturate.
                    if ((64'(v) >> SIZE_BITS) != 64'd0)
                        v = 32'((64'd1 << SIZE_BITS) - 64'd1);
                    field_value = v;
                    data_left   = v;
                    parse_phase = PH_DATA;
                end
            end
        end else begin
            r.byte_kind = KIND_DATA;
            if (data_left == field_value)
                r.arg_start = 1'b1;
            data_left = data_left - 32'd1;
            if (data_left == 32'd0) begin
                r.arg_end   = 1'b1;
                field_value = '0;
                close_arg();
            end
        end
        r.status = sticky;
        if (fin) begin
            if (sticky == ST_OK) begin
                if (parse_phase == PH_HEADER)
                    r.status = ST_SHORT;
                else if (parse_phase != PH_DONE)
                    r.status = ST_TRUNC;
            end
            clear_parse();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            clear_parse();
            max_args = MAX_ARGS_RESET;
            expected_labels.delete();
        end else begin
            // Outputs first: a result can never belong to an item taken at this same edge.
            if (i_out_valid && i_out_ready) begin
                got.byte_kind = t_kind'(i_out_user[1:0]);
                got.arg_start = i_out_user[2];
                got.arg_end   = i_out_user[3];
                got.data_byte = i_out_data[7:0];
                got.arg_index = i_out_data[23:8];
                got.status    = t_status'(i_out_data[26:24]);
                got.msg_done  = i_out_last;
                if (expected_labels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: unexpected result kind=%0d byte=%02h idx=%0d status=%0d",
                                 $realtime, got.byte_kind, got.data_byte, got.arg_index,
                                 got.status);
                end else begin
                    want = expected_labels.pop_front();
                    if (got != want || i_out_data[31:27] != 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%t: mismatch exp kind=%0d byte=%02h idx=%0d st=%0b ",
                                      "end=%0b done=%0b status=%0d | got kind=%0d byte=%02h ",
                                      "idx=%0d st=%0b end=%0b done=%0b status=%0d pad=%0h"},
                                     $realtime, want.byte_kind, want.data_byte,
                                     want.arg_index, want.arg_start, want.arg_end,
                                     want.msg_done, want.status, got.byte_kind,
                                     got.data_byte, got.arg_index, got.arg_start,
                                     got.arg_end, got.msg_done, got.status,
                                     i_out_data[31:27]);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                max_args = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_labels.insert(expected_labels.size(),
                                       classify_byte(i_in_data[7:0], i_in_last));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_labels.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/length_prefixed_request_parser_top_tb.sv
// Testbench top for the length-prefixed request parser: stimulus, handshakes and verdict.
`default_nettype none

module length_prefixed_request_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpr_pkg::*;

    // All block inputs start at known values; reset is held from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [15:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tready = 1'b0;

    logic                 o_cfg_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    int fail_count;
    int pending;

    // Handshake flags captured at the rising edge and read back at the falling edge,
    // so the driving code never races the block's own output updates.
    logic byte_taken = 1'b0;
    logic cfg_taken  = 1'b0;

    // While set, neither side inserts idle cycles.
    logic steady = 1'b0;

    logic [15:0] cfg_max = MAX_ARGS_RESET;   // limit currently programmed
    logic [7:0]  request_bytes[$];           // message being sent
    int          bytes_sent = 0;

    always #4 i_clk = ~i_clk;

    length_prefixed_request_parser_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lpr_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        byte_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken  <= i_cfg_valid && o_cfg_ready;
    end

    // The receiver stalls at random, with a chance of 13 in 100, unless a steady stretch runs.
    always @(negedge i_clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 13);

    // Presents one byte, possibly after a few random idle cycles, and returns at the
    // falling edge after it was accepted. Valid is left high so back-to-back bytes
    // never see it dropped and raised within one time step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(negedge i_clk); while (!byte_taken);
        bytes_sent++;
    endtask

    // Sends the whole message in request_bytes, flagging its final byte.
    task automatic send_request();
        for (int k = 0; k < request_bytes.size(); k++)
            send_byte(request_bytes[k], k == request_bytes.size() - 1);
    endtask

    // The sender holds off until every expected result has come out or a guard expires,
    // then waits longer to cover the output latency.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Writes the argument-count limit; only called while the parser is idle.
    task automatic write_max_args(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        cfg_max = v;
        @(negedge i_clk);
    endtask

    // Appends one byte to the message being built.
    function automatic void append_byte(input logic [7:0] v);
        request_bytes.insert(request_bytes.size(), v);
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            append_byte(w[8*k +: 8]);
    endfunction

    // Builds one random message. Most are well formed so the length and data phases
    // get real exercise; the rest are cut short, carry surplus bytes, announce too
    // many arguments, carry an enormous length, or are plain noise.
    task automatic make_request();
        int unsigned mode;
        int unsigned n_args;
        int unsigned len;
        int unsigned cut;
        logic [31:0] count;
        request_bytes.delete();
        mode   = $urandom_range(99);
        n_args = ($urandom_range(7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
        if (n_args > cfg_max)
            n_args = 32'(cfg_max);
        if (mode >= 88 && mode < 94) begin
            // Count above the limit: everything after the header is ignored.
            if ($urandom_range(3) == 0)
                count = $urandom | 32'h0100_0000;
            else
                count = 32'(cfg_max) + 32'd1 + 32'($urandom_range(0, 20));
            push_word(count);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
        end else if (mode >= 97) begin
            repeat ($urandom_range(1, 10)) append_byte(8'($urandom));
        end else if (mode >= 94 && cfg_max != 16'd0) begin
            // One argument whose length far exceeds what follows.
            push_word(32'd1);
            push_word({8'($urandom_range(1, 255)), 24'($urandom)});
            repeat ($urandom_range(0, 8)) append_byte(8'($urandom));
        end else begin
            push_word(32'(n_args));
            repeat (n_args) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 5);
                push_word(32'(len));
                repeat (len) append_byte(8'($urandom));
            end
            if (mode >= 70 && mode < 80) begin
                // Truncate anywhere inside the message.
                cut = $urandom_range(1, request_bytes.size() - 1);
                while (request_bytes.size() > cut)
                    void'(request_bytes.pop_back());
            end else if (mode >= 80 && mode < 88) begin
                repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
            end
        end
    endtask

    task automatic run_requests(input int target);
        while (bytes_sent < target) begin
            make_request();
            send_request();
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed messages, limit at its reset value of 1024.
        // Two arguments, the first empty (its end mark falls on the length field),
        // the second a single byte that both starts and ends it.
        request_bytes = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_request();
        // A lone byte: the header never completes.
        request_bytes = '{8'h7F};
        send_request();
        // Count of zero, then a surplus byte.
        request_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
        send_request();
        // Count of 1025, one above the limit.
        request_bytes = '{8'h01, 8'h04, 8'h00, 8'h00};
        send_request();
        // One argument announced, then the message stops before its length.
        request_bytes = '{8'h01, 8'h00, 8'h00, 8'h00};
        send_request();

        // Random phases under a series of limits, with a full drain before
        // every limit change.
        run_requests(400);
        wait_drained();
        write_max_args(16'd0);
        run_requests(650);
        wait_drained();
        write_max_args(16'hFFFF);
        steady = 1'b1;
        run_requests(1000);
        steady = 1'b0;
        wait_drained();
        write_max_args(16'd3);
        run_requests(1350);
        wait_drained();
        write_max_args(16'($urandom_range(1, 65534)));
        run_requests(1650);
        wait_drained();
        write_max_args(MAX_ARGS_RESET);
        run_requests(1900);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("length_prefixed_request_parser_top_tb passed");
        end else begin
            $display("length_prefixed_request_parser_top_tb failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of a few thousand bytes.
    initial begin
        #2_000_000;
        $display("length_prefixed_request_parser_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
